FILE: src/ucc_pkg.sv
// Package with shared types and constants of the unitig coverage classifier.
`default_nettype none
package ucc_pkg;
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_READ_HIST = 2'd1;
  localparam logic [1:0] OP_READ_CNT = 2'd2;

  localparam logic [1:0] HIST_KMER = 2'd0;
  localparam logic [1:0] HIST_MEAN = 2'd1;
  localparam logic [1:0] HIST_LEN = 2'd2;

  localparam logic [1:0] CLS_KEPT = 2'd0;
  localparam logic [1:0] CLS_BOTH = 2'd1;
  localparam logic [1:0] CLS_LOW = 2'd2;
  localparam logic [1:0] CLS_TIP = 2'd3;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_MINTIP = 2'd2;

  localparam int CntNum = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLASS,
    ST_REPLAY_RD,
    ST_REPLAY_WR,
    ST_MEAN_RD,
    ST_MEAN_WR,
    ST_LEN_RD,
    ST_LEN_WR,
    ST_READ,
    ST_OUT
  } state_e;

  // Result of the divider, handed to the sequencer.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_status_t;
endpackage
`default_nettype wire

FILE: src/unitig_coverage_classifier_top.sv
// Top level of the unitig coverage classifier: sequencer, buffer, counters.
`default_nettype none
// Coverages of a path come in one transaction at a time; a transaction that does not end a path
// is accepted, then written to the buffer and added to the sum. At the last element a bit-serial
// divider forms the mean; then, unless mode is set and the path is classed low or tip, the
// histogram stage replays the buffered coverages through one read-modify-write port, followed
// by the mean and length bins. A read transaction passes through the ST_READ and ST_OUT states
// for the registered memory read. The block takes no new transaction while a result waits in
// the output register. After reset every histogram is cleared by a pass of one bin per cycle,
// and the block is not ready until all three passes are done.
module unitig_coverage_classifier_top #(
  parameter int COVG_BINS = 1024,
  parameter int MEAN_BINS = 1024,
  parameter int LEN_BINS  = 1024,
  parameter int MAX_PATH  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[1:0], coverage[33:2], end_is_tip[34], histogram_select[36:35],
  // bin_index[46:37], counter_select[49:47], zero fill to 56 bits
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // keep[0], path_class[2:1], mean_coverage[34:3], path_length[50:35], overflow[51],
  // read_value[115:52], zero fill to 120 bits
  output logic [119:0]     m_axis_tdata
);
  import ucc_pkg::*;

  localparam int CAW = $clog2(COVG_BINS);
  localparam int MAW = $clog2(MEAN_BINS);
  localparam int LAW = $clog2(LEN_BINS);
  localparam int BAW = $clog2(MAX_PATH);
  localparam logic [16:0] MaxPath17 = 17'(MAX_PATH);

  state_e state_q, state_d;
  logic mode_q;
  logic [31:0] thresh_q;
  logic [15:0] mintip_q;

  logic [1:0]  op_q;
  logic [31:0] cov_q;
  logic        last_q, tip_q;
  logic [1:0]  hsel_q;
  logic [9:0]  bin_q;
  logic [15:0] bin16;
  logic [2:0]  csel_q;
  logic        push_pend_q, push_pend_d;

  logic [63:0] sum_q, sum_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [63:0] ctr_q [CntNum];
  logic [31:0] mean_q, mean_d;
  logic [1:0]  cls_q, cls_d;
  logic [16:0] rp_q, rp_d;
  logic [16:0] rp_n;
  logic [16:0] buf_ra;
  logic [31:0] buf_mem [MAX_PATH];
  logic [31:0] buf_rd_q;
  logic        buf_wr, buf_rd;

  logic        out_vld_q, out_vld_d;
  logic        out_keep_q, out_keep_d, out_ovf_q, out_ovf_d;
  logic [1:0]  out_cls_q, out_cls_d;
  logic [31:0] out_mean_q, out_mean_d;
  logic [15:0] out_len_q, out_len_d;
  logic [63:0] out_rv_q, out_rv_d;

  logic        div_start;
  div_status_t div_st;

  logic [CAW-1:0] k_addr;
  logic [MAW-1:0] m_addr;
  logic [LAW-1:0] l_addr;
  logic k_rd, k_wr, m_rd, m_wr, l_rd, l_wr;
  logic k_busy, m_busy, l_busy, hist_busy;
  logic [63:0] k_rdata, m_rdata, l_rdata, hist_wdata, hist_cur;
  logic [2:0]  ctr_sel;
  logic        ctr_inc;
  logic        accept;
  logic        rd_phase;
  logic [31:0] rp_cov;
  logic [64:0] sum_ext;
  logic        low, rtip;

  assign hist_busy = k_busy || m_busy || l_busy;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !push_pend_q && !out_vld_q && !hist_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      thresh_q <= 32'd0;
      mintip_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE: mode_q <= cfg_data_i[0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        CFG_MINTIP: mintip_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= s_axis_tdata[1:0];
      cov_q <= s_axis_tdata[33:2];
      last_q <= s_axis_tlast;
      tip_q <= s_axis_tdata[34];
      hsel_q <= s_axis_tdata[36:35];
      bin_q <= s_axis_tdata[46:37];
      csel_q <= s_axis_tdata[49:47];
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr) buf_mem[cnt_q[BAW-1:0]] <= cov_q;
    if (buf_rd) buf_rd_q <= buf_mem[buf_ra[BAW-1:0]];
  end

  ucc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .status_o   (div_st)
  );

  ucc_hist_mem #(.BINS(COVG_BINS)) u_kmer (
    .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(k_busy), .addr_i(k_addr), .rd_i(k_rd),
    .wr_i(k_wr), .wdata_i(hist_wdata), .rdata_o(k_rdata)
  );
  ucc_hist_mem #(.BINS(MEAN_BINS)) u_mean (
    .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(m_busy), .addr_i(m_addr), .rd_i(m_rd),
    .wr_i(m_wr), .wdata_i(hist_wdata), .rdata_o(m_rdata)
  );
  ucc_hist_mem #(.BINS(LEN_BINS)) u_len (
    .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(l_busy), .addr_i(l_addr), .rd_i(l_rd),
    .wr_i(l_wr), .wdata_i(hist_wdata), .rdata_o(l_rdata)
  );

  assign rd_phase = (state_q == ST_READ || state_q == ST_OUT);
  assign bin16 = {6'd0, bin_q};
  assign rp_cov = buf_rd_q;
  assign k_addr = rd_phase ? bin16[CAW-1:0] :
                  ((rp_cov >= 32'(COVG_BINS - 1)) ? CAW'(COVG_BINS - 1) : rp_cov[CAW-1:0]);
  assign m_addr = rd_phase ? bin16[MAW-1:0] :
                  ((mean_q >= 32'(MEAN_BINS - 1)) ? MAW'(MEAN_BINS - 1) : mean_q[MAW-1:0]);
  assign l_addr = rd_phase ? bin16[LAW-1:0] :
                  ((cnt_q >= 16'(LEN_BINS - 1)) ? LAW'(LEN_BINS - 1) : cnt_q[LAW-1:0]);
  assign hist_wdata = (&hist_cur) ? hist_cur : hist_cur + 64'd1;
  assign sum_ext = {1'b0, sum_q} + {33'd0, cov_q};
  assign low = mean_q < thresh_q;
  assign rtip = tip_q && (cnt_q < mintip_q);
  assign rp_n = rp_q + 17'd1;

  always_comb begin
    state_d = state_q;
    push_pend_d = push_pend_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    mean_d = mean_q;
    cls_d = cls_q;
    rp_d = rp_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_keep_d = out_keep_q;
    out_cls_d = out_cls_q;
    out_mean_d = out_mean_q;
    out_len_d = out_len_q;
    out_ovf_d = out_ovf_q;
    out_rv_d = out_rv_q;
    div_start = 1'b0;
    buf_wr = 1'b0;
    buf_rd = 1'b0;
    buf_ra = rp_q;
    k_rd = 1'b0; k_wr = 1'b0;
    m_rd = 1'b0; m_wr = 1'b0;
    l_rd = 1'b0; l_wr = 1'b0;
    hist_cur = 64'd0;
    ctr_inc = 1'b0;
    ctr_sel = 3'd0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tdata[1:0] == OP_PUSH) push_pend_d = 1'b1;
          else if (s_axis_tdata[1:0] == OP_READ_HIST || s_axis_tdata[1:0] == OP_READ_CNT) begin
            state_d = ST_READ;
          end
        end
        if (push_pend_q) begin
          push_pend_d = 1'b0;
          buf_wr = {1'b0, cnt_q} < MaxPath17;
          ovf_d = {1'b0, cnt_q} >= MaxPath17;
          if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
          sum_d = sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_ext[63:0];
          if (last_q) state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = !div_st.busy && !div_st.done;
        if (div_st.done) begin
          mean_d = div_st.quotient;
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (!mode_q) cls_d = CLS_KEPT;
        else if (low && rtip) cls_d = CLS_BOTH;
        else if (low) cls_d = CLS_LOW;
        else if (rtip) cls_d = CLS_TIP;
        else cls_d = CLS_KEPT;
        rp_d = 17'd0;
        state_d = (mode_q && (low || rtip)) ? ST_OUT : ST_REPLAY_RD;
        buf_rd = 1'b1;
        buf_ra = 17'd0;
        if (mode_q) begin
          if (low && rtip) ctr_sel = 3'd2;
          else if (low) ctr_sel = 3'd1;
          else ctr_sel = 3'd0;
          ctr_inc = low || rtip;
        end
      end
      ST_REPLAY_RD: begin
        // Buffer data is valid now; fetch the bin it lands in.
        if (rp_q >= {1'b0, cnt_q} || rp_q >= MaxPath17) begin
          state_d = ST_MEAN_RD;
          m_rd = 1'b1;
        end else begin
          k_rd = 1'b1;
          state_d = ST_REPLAY_WR;
        end
      end
      ST_REPLAY_WR: begin
        hist_cur = k_rdata;
        k_wr = 1'b1;
        rp_d = rp_n;
        buf_rd = 1'b1;
        buf_ra = rp_n;
        state_d = ST_REPLAY_RD;
      end
      ST_MEAN_RD: state_d = ST_MEAN_WR;
      ST_MEAN_WR: begin
        hist_cur = m_rdata;
        m_wr = 1'b1;
        l_rd = 1'b1;
        state_d = ST_LEN_RD;
      end
      ST_LEN_RD: state_d = ST_LEN_WR;
      ST_LEN_WR: begin
        hist_cur = l_rdata;
        l_wr = 1'b1;
        state_d = ST_OUT;
      end
      ST_READ: begin
        k_rd = hsel_q == HIST_KMER;
        m_rd = hsel_q == HIST_MEAN;
        l_rd = hsel_q == HIST_LEN;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_vld_d = 1'b1;
        state_d = ST_IDLE;
        if (op_q == OP_PUSH) begin
          out_keep_d = cls_q == CLS_KEPT;
          out_cls_d = cls_q;
          out_mean_d = mean_q;
          out_len_d = cnt_q;
          out_ovf_d = ovf_q;
          out_rv_d = 64'd0;
          sum_d = 64'd0;
          cnt_d = 16'd0;
          ovf_d = 1'b0;
        end else begin
          out_keep_d = 1'b0;
          out_cls_d = CLS_KEPT;
          out_mean_d = 32'd0;
          out_len_d = 16'd0;
          out_ovf_d = 1'b0;
          out_rv_d = 64'd0;
          if (op_q == OP_READ_HIST) begin
            if (hsel_q == HIST_KMER && 32'(bin_q) < 32'(COVG_BINS)) out_rv_d = k_rdata;
            else if (hsel_q == HIST_MEAN && 32'(bin_q) < 32'(MEAN_BINS)) out_rv_d = m_rdata;
            else if (hsel_q == HIST_LEN && 32'(bin_q) < 32'(LEN_BINS)) out_rv_d = l_rdata;
          end else if (32'(csel_q) < CntNum) begin
            out_rv_d = ctr_q[csel_q];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Overflow flag holds the status of the last element only.
  logic [64:0] ctr_a, ctr_b;
  assign ctr_a = {1'b0, ctr_q[ctr_sel]} + 65'd1;
  assign ctr_b = {1'b0, ctr_q[ctr_sel + 3'd3]} + {49'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      push_pend_q <= 1'b0;
      sum_q <= 64'd0;
      cnt_q <= 16'd0;
      ovf_q <= 1'b0;
      out_vld_q <= 1'b0;
      rp_q <= 17'd0;
      for (int i = 0; i < CntNum; i++) ctr_q[i] <= 64'd0;
    end else begin
      state_q <= state_d;
      push_pend_q <= push_pend_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      out_vld_q <= out_vld_d;
      rp_q <= rp_d;
      if (ctr_inc) begin
        ctr_q[ctr_sel] <= ctr_a[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ctr_a[63:0];
        ctr_q[ctr_sel + 3'd3] <= ctr_b[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ctr_b[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    cls_q <= cls_d;
    out_keep_q <= out_keep_d;
    out_cls_q <= out_cls_d;
    out_mean_q <= out_mean_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
    out_rv_q <= out_rv_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {4'd0, out_rv_q, out_ovf_q, out_len_q, out_mean_q, out_cls_q,
                         out_keep_q};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPLAY_WR) |-> (rp_q < MaxPath17)) else $error("replay past buffer");
endmodule
`default_nettype wire

FILE: src/ucc_divider.sv
// Restoring divider of a 64-bit sum by a 16-bit count, one quotient bit a cycle.
`default_nettype none
module ucc_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [63:0]         dividend_i,
  input  wire logic [15:0]         divisor_i,
  output ucc_pkg::div_status_t     status_o
);
  import ucc_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    trial = {rem_q[15:0], quo_q[63]};
    diff = {1'b0, trial} - {2'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      quo_d = dividend_i;
      rem_d = 17'd0;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[16:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  // The mean saturates at all ones.
  assign status_o.quotient = (|quo_q[63:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule
`default_nettype wire

FILE: src/ucc_hist_mem.sv
// Histogram memory with a single address for a registered read and a write; the top level saturates the bins.
`default_nettype none
module ucc_hist_mem #(
  parameter int BINS = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  output logic                         busy_o,
  input  wire logic [$clog2(BINS)-1:0] addr_i,
  input  wire logic                    rd_i,
  input  wire logic                    wr_i,
  input  wire logic [63:0]             wdata_i,
  output logic      [63:0]             rdata_o
);
  import ucc_pkg::*;
  localparam int AW = $clog2(BINS);

  logic [63:0]   mem [BINS];
  logic [63:0]   rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // After reset one bin per cycle is written to zero before the store is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(BINS - 1)) clr_busy_q <= 1'b0;
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) mem[clr_addr_q] <= 64'd0;
    else if (wr_i) mem[addr_i] <= wdata_i;
    if (rd_i) rd_q <= mem[addr_i];
  end

  assign busy_o = clr_busy_q;
  assign rdata_o = rd_q;
endmodule
`default_nettype wire
